/* src/hafe_pkg.sv */
// Shared types, constants and helper functions of the hex-ASCII frame encoder.
`timescale 1ns / 1ps

package hafe_pkg;

    // Reflected CRC-32 polynomial
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;

    // Register reset values
    localparam logic [7:0] START_CHAR_RST = 8'h3C;
    localparam logic [7:0] END_CHAR_RST   = 8'h0A;

    // Register map
    localparam int          NUM_REGS  = 2;
    localparam int          ADDR_W    = 3;
    localparam logic [0:0]  REG_START = 1'b0;
    localparam logic [0:0]  REG_END   = 1'b1;

    // Command queue between front and back (depth must be a power of two)
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
    localparam int COUNT_W    = FIFO_AW + 1;

    // One queued byte command
    typedef struct packed {
        logic [7:0]  data;
        logic        opening;
        logic        closing;
        logic [31:0] crc;
    } hafe_cmd_t;

    // Advance the reflected CRC by one byte
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in, input logic [7:0] b);
        logic [31:0] c;
        c = crc_in ^ {24'h0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // Upper-case ASCII hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = 8'h30 + {4'h0, nib};
        end else begin
            ch = 8'h37 + {4'h0, nib};
        end
        return ch;
    endfunction

endpackage

/* src/hex_ascii_frame_encoder_crc32_unit.sv */
// Top level of the hex-ASCII frame encoder with CRC-32.
//
//   port group   dir   fields                          meaning
//   s_*          in    payload_byte[7:0], last_byte    one payload byte per beat
//   m_*          out   out_char[7:0], frame_end        one ASCII character per beat
//   APB          in    start_char @0x0, end_char @0x4  framing characters
//
// The output side moves one character per cycle while m_ready is high; a middle byte
// yields 2 characters, the opening byte 3 and the closing byte 11. A 4-entry command
// queue sits between the CRC front end and the character sequencer, so input beats
// are taken while earlier bytes still drain.
// Reset (aresetn low, synchronous) empties the queue, clears the CRC and the
// framing state and restores the characters; m_ready low stalls the back end,
// and the front end stalls (s_ready low) once the queue is full.
`timescale 1ns / 1ps

module hex_ascii_frame_encoder_crc32_unit
    import hafe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // payload input
    input  logic              s_valid,
    output logic              s_ready,
    input  logic [7:0]        s_payload_byte,
    input  logic              s_last_byte,
    // character output
    output logic              m_valid,
    input  logic              m_ready,
    output logic [7:0]        m_out_char,
    output logic              m_frame_end,
    // register port
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    logic [7:0] start_char_reg, start_char_next;
    logic [7:0] end_char_reg, end_char_next;
    logic       reg_wr;
    logic [0:0] reg_idx;

    logic       q_full;
    logic       q_push;
    logic       q_pop;
    logic       q_not_empty;
    hafe_cmd_t  q_wdata;
    hafe_cmd_t  q_rdata;

    // Register port
    assign pready  = 1'b1;
    assign reg_wr  = psel && penable && pwrite;
    assign reg_idx = paddr[2];

    always_comb begin
        start_char_next = start_char_reg;
        end_char_next   = end_char_reg;
        if (reg_wr) begin
            unique case (reg_idx)
                REG_START: start_char_next = pwdata[7:0];
                REG_END:   end_char_next   = pwdata[7:0];
                default:   ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_START: prdata = {24'h0, start_char_reg};
            REG_END:   prdata = {24'h0, end_char_reg};
            default:   prdata = 32'h0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_char_reg <= START_CHAR_RST;
            end_char_reg   <= END_CHAR_RST;
        end else begin
            start_char_reg <= start_char_next;
            end_char_reg   <= end_char_next;
        end
    end

    // Front end: framing and CRC
    hafe_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_data         (q_wdata)
    );

    // Command queue
    hafe_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_data  (q_rdata)
    );

    // Back end: character sequencer
    hafe_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_data      (q_rdata),
        .q_pop       (q_pop),
        .start_char  (start_char_reg),
        .end_char    (end_char_reg),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_char  (m_out_char),
        .m_frame_end (m_frame_end)
    );

endmodule

/* src/hafe_front.sv */
// Front end: accepts payload beats, tracks framing and runs the CRC.
`timescale 1ns / 1ps

module hafe_front
    import hafe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_payload_byte,
    input  logic       s_last_byte,
    input  logic       q_full,
    output logic       q_push,
    output hafe_cmd_t  q_data
);

    logic [31:0] crc_reg, crc_next;
    logic        inside_reg, inside_next;
    logic        opening;
    logic        closing;
    logic [31:0] crc_new;

    // Take a beat whenever the queue has room
    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full;

    // Classify the beat and advance the CRC
    assign opening = !inside_reg;
    assign closing = s_last_byte && !opening;
    assign crc_new = crc_byte(opening ? 32'h0 : crc_reg, s_payload_byte);

    assign q_data = '{data: s_payload_byte, opening: opening, closing: closing, crc: crc_new};

    // On a pushed beat, drop the CRC and leave the frame if it closes; else keep the new CRC and stay inside
    always_comb begin
        crc_next    = crc_reg;
        inside_next = inside_reg;
        if (q_push) begin
            if (closing) begin
                crc_next    = 32'h0;
                inside_next = 1'b0;
            end else begin
                crc_next    = crc_new;
                inside_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg    <= 32'h0;
            inside_reg <= 1'b0;
        end else begin
            crc_reg    <= crc_next;
            inside_reg <= inside_next;
        end
    end

endmodule

/* src/hafe_queue.sv */
// Small command queue between the front and back ends.
`timescale 1ns / 1ps

module hafe_queue
    import hafe_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      push,
    input  hafe_cmd_t push_data,
    output logic      full,
    input  logic      pop,
    output logic      not_empty,
    output hafe_cmd_t pop_data
);

    hafe_cmd_t              entry_reg [FIFO_DEPTH];
    logic [FIFO_AW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [COUNT_W-1:0]     count_reg, count_next;

    assign full      = (count_reg == COUNT_W'(FIFO_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Store the pushed command
    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

/* src/hafe_back.sv */
// Back end: expands queued commands into ASCII characters, one per cycle while m_ready is high.
`timescale 1ns / 1ps

module hafe_back
    import hafe_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       q_not_empty,
    input  hafe_cmd_t  q_data,
    output logic       q_pop,
    input  logic [7:0] start_char,
    input  logic [7:0] end_char,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_char,
    output logic       m_frame_end
);

    // Character positions within one command
    localparam logic [3:0] POS_START = 4'd0;
    localparam logic [3:0] POS_HI    = 4'd1;
    localparam logic [3:0] POS_LO    = 4'd2;
    localparam logic [3:0] POS_CRC0  = 4'd3;
    localparam logic [3:0] POS_END   = 4'd11;

    hafe_cmd_t  cmd_reg, cmd_next;
    logic       busy_reg, busy_next;
    logic [3:0] pos_reg, pos_next;
    logic       m_valid_reg, m_valid_next;
    logic [7:0] m_char_reg, m_char_next;
    logic       m_end_reg, m_end_next;

    logic       out_load;
    logic       pos_last;
    logic [3:0] crc_idx;
    logic [7:0] crc_sel;
    logic [7:0] ch;

    assign m_valid     = m_valid_reg;
    assign m_out_char  = m_char_reg;
    assign m_frame_end = m_end_reg;

    // Emit when the output register is free or being drained
    assign out_load = busy_reg && (!m_valid_reg || m_ready);
    assign pos_last = (pos_reg == POS_END) || ((pos_reg == POS_LO) && !cmd_reg.closing);
    assign q_pop    = q_not_empty && (!busy_reg || (out_load && pos_last));

    // Pick the CRC byte, low byte first
    assign crc_idx = pos_reg - POS_CRC0;
    always_comb begin
        unique case (crc_idx[2:1])
            2'd0:    crc_sel = cmd_reg.crc[7:0];
            2'd1:    crc_sel = cmd_reg.crc[15:8];
            2'd2:    crc_sel = cmd_reg.crc[23:16];
            default: crc_sel = cmd_reg.crc[31:24];
        endcase
    end

    // Select the character for the current position
    always_comb begin
        if (pos_reg == POS_START) begin
            ch = start_char;
        end else if (pos_reg == POS_HI) begin
            ch = hex_digit(cmd_reg.data[7:4]);
        end else if (pos_reg == POS_LO) begin
            ch = hex_digit(cmd_reg.data[3:0]);
        end else if (pos_reg == POS_END) begin
            ch = end_char;
        end else begin
            ch = hex_digit(crc_idx[0] ? crc_sel[3:0] : crc_sel[7:4]);
        end
    end

    // Sequence the command and load the output register
    always_comb begin
        cmd_next     = cmd_reg;
        busy_next    = busy_reg;
        pos_next     = pos_reg;
        m_valid_next = m_valid_reg;
        m_char_next  = m_char_reg;
        m_end_next   = m_end_reg;

        if (out_load) begin
            m_valid_next = 1'b1;
            m_char_next  = ch;
            m_end_next   = (pos_reg == POS_END);
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end

        if (q_pop) begin
            cmd_next  = q_data;
            busy_next = 1'b1;
            pos_next  = q_data.opening ? POS_START : POS_HI;
        end else if (out_load) begin
            if (pos_last) begin
                busy_next = 1'b0;
            end else if (pos_reg == POS_LO) begin
                pos_next = POS_CRC0;
            end else begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pos_reg     <= POS_START;
            m_valid_reg <= 1'b0;
        end else begin
            busy_reg    <= busy_next;
            pos_reg     <= pos_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        cmd_reg    <= cmd_next;
        m_char_reg <= m_char_next;
        m_end_reg  <= m_end_next;
    end

endmodule

/* bench/frame_char_checker.sv */
// Watches the payload, character and register ports, predicts each encoded character and checks it.
`timescale 1ns / 1ps

module frame_char_checker
    import hafe_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    input  logic              s_ready,
    input  logic [7:0]        s_payload_byte,
    input  logic              s_last_byte,
    input  logic              m_valid,
    input  logic              m_ready,
    input  logic [7:0]        m_out_char,
    input  logic              m_frame_end,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    input  logic              pready,
    output int                mismatch_count,
    output int                pending_chars
);

    localparam logic [7:0] ASCII_ZERO = 8'h30;
    localparam logic [7:0] ASCII_A    = 8'h41;

    typedef struct packed {
        logic [7:0] ch;
        logic       fend;
    } frame_char_t;

    // Predicted characters, oldest first
    frame_char_t expected_chars[$];

    // Encoder state mirrored from the register port and the payload beats
    logic [31:0] crc_run       = '0;
    logic        in_frame      = 1'b0;
    logic [7:0]  start_char_q  = START_CHAR_RST;
    logic [7:0]  end_char_q    = END_CHAR_RST;
    int          errors        = 0;

    // Shift one byte into the reflected CRC, LSB first
    function automatic logic [31:0] crc32_step(input logic [31:0] crc, input logic [7:0] data);
        logic [31:0] r;
        logic        fb;
        r = crc;
        for (int i = 0; i < 8; i++) begin
            fb = r[0] ^ data[i];
            r  = r >> 1;
            if (fb) begin
                r = r ^ CRC_POLY;
            end
        end
        return r;
    endfunction

    // Upper-case ASCII digit of one nibble
    function automatic logic [7:0] hex_ascii(input logic [3:0] nib);
        logic [7:0] ch;
        if (nib < 4'd10) begin
            ch = ASCII_ZERO + 8'(nib);
        end else begin
            ch = ASCII_A + 8'(nib) - 8'd10;
        end
        return ch;
    endfunction

    task automatic push_char(input logic [7:0] ch, input logic fend);
        frame_char_t c;
        c.ch   = ch;
        c.fend = fend;
        expected_chars.push_back(c);
    endtask

    task automatic push_hex_pair(input logic [7:0] data);
        push_char(hex_ascii(data[7:4]), 1'b0);
        push_char(hex_ascii(data[3:0]), 1'b0);
    endtask

    // Predict the characters caused by one payload beat
    task automatic encode_byte(input logic [7:0] data, input logic last);
        logic       opening;
        logic [7:0] crc_octet;
        opening = !in_frame;
        if (opening) begin
            crc_run = '0;
            push_char(start_char_q, 1'b0);
        end
        push_hex_pair(data);
        crc_run = crc32_step(crc_run, data);
        // a last flag on the opening byte is dropped: a frame has two bytes at least
        if (last && !opening) begin
            for (int k = 0; k < 4; k++) begin
                crc_octet = 8'(crc_run >> (8 * k));
                push_hex_pair(crc_octet);
            end
            push_char(end_char_q, 1'b1);
            crc_run  = '0;
            in_frame = 1'b0;
        end else begin
            in_frame = 1'b1;
        end
    endtask

    // Compare one character beat against the oldest prediction
    task automatic check_char(input logic [7:0] ch, input logic fend);
        frame_char_t want;
        if (expected_chars.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat, expected none, actual char 0x%02h frame_end %0b",
                     $time, ch, fend);
            return;
        end
        want = expected_chars.pop_front();
        if (ch !== want.ch) begin
            errors++;
            $display("%0t: out_char mismatch, expected 0x%02h, actual 0x%02h",
                     $time, want.ch, ch);
        end
        if (fend !== want.fend) begin
            errors++;
            $display("%0t: frame_end mismatch, expected %0b, actual %0b",
                     $time, want.fend, fend);
        end
    endtask

    // Track registers, predict on input beats, check on output beats
    always @(posedge aclk) begin
        if (!aresetn) begin
            crc_run      = '0;
            in_frame     = 1'b0;
            start_char_q = START_CHAR_RST;
            end_char_q   = END_CHAR_RST;
            expected_chars.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr[ADDR_W-1:2] == REG_START) begin
                    start_char_q = pwdata[7:0];
                end else if (paddr[ADDR_W-1:2] == REG_END) begin
                    end_char_q = pwdata[7:0];
                end
            end
            if (s_valid && s_ready) begin
                encode_byte(s_payload_byte, s_last_byte);
            end
            if (m_valid && m_ready) begin
                check_char(m_out_char, m_frame_end);
            end
        end
        mismatch_count <= errors;
        pending_chars  <= expected_chars.size();
    end

endmodule

/* bench/hex_ascii_frame_encoder_crc32_unit_tb.sv */
// Top of the frame encoder bench: clock, reset, payload and register stimulus, verdict.
`timescale 1ns / 1ps

module hex_ascii_frame_encoder_crc32_unit_tb;
    import hafe_pkg::*;

    localparam int RANDOM_ITEMS = 400;
    localparam int DRAIN_CYCLES = 30;

    logic              aclk           = 1'b0;
    logic              aresetn        = 1'b0;
    logic              s_valid        = 1'b0;
    logic              s_ready;
    logic [7:0]        s_payload_byte = '0;
    logic              s_last_byte    = 1'b0;
    logic              m_valid;
    logic              m_ready        = 1'b0;
    logic [7:0]        m_out_char;
    logic              m_frame_end;
    logic              psel           = 1'b0;
    logic              penable        = 1'b0;
    logic              pwrite         = 1'b0;
    logic [ADDR_W-1:0] paddr          = '0;
    logic [31:0]       pwdata         = '0;
    logic [31:0]       prdata;
    logic              pready;

    int mismatch_count;
    int pending_chars;
    bit tx_burst = 1'b0;
    bit rx_burst = 1'b0;

    hex_ascii_frame_encoder_crc32_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_frame_end    (m_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready)
    );

    frame_char_checker checker_i (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload_byte (s_payload_byte),
        .s_last_byte    (s_last_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_char     (m_out_char),
        .m_frame_end    (m_frame_end),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .pready         (pready),
        .mismatch_count (mismatch_count),
        .pending_chars  (pending_chars)
    );

    initial begin
        forever #6 aclk = ~aclk;
    end

    // Hard stop for a hung run
    initial begin
        #10_000_000;
        $display("[hex_ascii_frame_encoder_crc32_unit] ERROR");
        $finish;
    end

    // Offer one payload beat after a random gap and hold it until taken
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        if ($urandom_range(0, 29) == 0) begin
            tx_burst = !tx_burst;
        end
        gap = tx_burst ? 0 : $urandom_range(0, 14);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_payload_byte <= data;
        s_last_byte    <= last;
        do @(posedge aclk); while (!s_ready);
    endtask

    // Stop sending and hold until every predicted character has come out
    task automatic wait_idle();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_chars != 0);
    endtask

    // One register write: setup cycle, access cycle, then a bus idle cycle
    task automatic write_reg(input logic [0:0] idx, input logic [7:0] value);
        logic [23:0] filler;
        filler = 24'($urandom);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_W'({idx, 2'b00});
        pwdata  <= {filler, value};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [7:0] pick_char();
        case ($urandom_range(0, 3))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 15))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // Draw a random stall ahead of each character beat
    initial begin
        int stall;
        do @(posedge aclk); while (!aresetn);
        forever begin
            if ($urandom_range(0, 31) == 0) begin
                rx_burst = !rx_burst;
            end
            stall = rx_burst ? 0 : $urandom_range(0, 14);
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    // Stimulus and verdict
    initial begin
        int sent;
        int phase_len;
        int phase_sent;
        int frame_len;
        logic last;

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Reset characters; last flag on the opening byte, all hex digits, shortest frame
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b0);
        send_byte(8'h01, 1'b1);
        send_byte(8'h23, 1'b0);
        send_byte(8'h45, 1'b0);
        send_byte(8'h67, 1'b0);
        send_byte(8'h89, 1'b0);
        send_byte(8'hAB, 1'b0);
        send_byte(8'hCD, 1'b0);
        send_byte(8'hEF, 1'b1);
        send_byte(8'h5A, 1'b0);
        send_byte(8'hA5, 1'b1);
        wait_idle();

        // Extreme framing characters
        write_reg(REG_START, 8'h00);
        write_reg(REG_END, 8'hFF);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b1);
        wait_idle();
        write_reg(REG_END, 8'h00);
        write_reg(REG_START, 8'hFF);
        send_byte(8'h80, 1'b0);
        send_byte(8'h7F, 1'b1);
        wait_idle();

        // Random phases, each under its own framing characters
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            case ($urandom_range(0, 3))
                0: write_reg(REG_START, pick_char());
                1: write_reg(REG_END, pick_char());
                default: begin
                    write_reg(REG_END, pick_char());
                    write_reg(REG_START, pick_char());
                end
            endcase
            phase_len  = $urandom_range(30, 80);
            phase_sent = 0;
            while (phase_sent < phase_len) begin
                frame_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                        : $urandom_range(2, 12);
                for (int i = 0; i < frame_len; i++) begin
                    last = (i == frame_len - 1);
                    // broken framing now and then: stray or missing last flags
                    if ($urandom_range(0, 19) == 0) begin
                        last = 1'($urandom_range(0, 1));
                    end
                    send_byte(pick_byte(), last);
                    if ($urandom_range(0, 59) == 0) begin
                        wait_idle();
                    end
                end
                phase_sent += frame_len;
            end
            sent += phase_sent;
            wait_idle();
        end

        // Drain, then allow stray beats to show up
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("[hex_ascii_frame_encoder_crc32_unit] OK");
        end else begin
            $display("[hex_ascii_frame_encoder_crc32_unit] ERROR");
        end
        $finish;
    end

endmodule

/* hex_ascii_frame_encoder_crc32_unit.f */
src/hafe_pkg.sv
src/hafe_front.sv
src/hafe_queue.sv
src/hafe_back.sv
src/hex_ascii_frame_encoder_crc32_unit.sv
bench/frame_char_checker.sv
bench/hex_ascii_frame_encoder_crc32_unit_tb.sv
